[hw/rtl/sfq_pkg.sv]
// shared constants, types and width helpers for the surface frame quaternion block
package sfq_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 14;

    // which quaternion component comes from the square root
    typedef enum logic [1:0] {
        MAIN_W = 2'd0,
        MAIN_X = 2'd1,
        MAIN_Y = 2'd2,
        MAIN_Z = 2'd3
    } t_main;

    // result bits of the square root of (arg << (f+2)), arg being w+3 bits
    function automatic int sqrt_bits(input int w, input int f);
        int rw;
        rw = (w + 3) + f + 2;
        return (rw + 1) / 2;
    endfunction

endpackage

[hw/rtl/surface_frame_to_quaternion_pair.sv]
// top level: surface frame to quaternion pair pipeline with output skid
//
// usage
//   input channel (i_in_valid / o_in_ready) takes one point per item: unit
//   normal and unit curvature direction, signed fixed point with FRAC_BITS
//   fraction bits. output channel (o_out_valid / i_out_ready) gives one item
//   per point: the quaternion of the frame [n c n x c] and the quaternion of
//   the same frame with its second and third columns negated.
//   throughput: one item per cycle while the receiver keeps ready high.
//   path: frame, branch select, square root (one result bit per stage,
//   SW = ceil((SAMPLE_WIDTH + FRAC_BITS + 5) / 2) being the root width),
//   then the restoring divide (prep, one quotient bit per stage, output).
//   reset clears all valid bits and the skid flag; no clearing pass.
//   receiver stall: one result is parked in a skid register and input keeps
//   flowing for that cycle; once the skid is full the whole pipeline holds
//   and o_in_ready drops until the skid item is taken.
module surface_frame_to_quaternion_pair
    import sfq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_normal_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_normal_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_normal_z,
    input  logic signed [SAMPLE_WIDTH-1:0] i_curv_dir_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_curv_dir_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_curv_dir_z,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_w,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_z,
    output logic signed [SAMPLE_WIDTH-1:0] o_flip_w,
    output logic signed [SAMPLE_WIDTH-1:0] o_flip_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_flip_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_flip_z
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int SW     = sqrt_bits(SAMPLE_WIDTH, FRAC_BITS);
    localparam int QB     = W + 1;
    // frame (2) + branch (1) + root (SW) + divide prep, bits, output (QB + 2)
    localparam int NST    = 3 + SW + QB + 2;
    localparam int SIDE_W = 3 * (W + 2) + 2;

    // pipeline valid bits, one per register stage
    logic [NST-1:0] r_vld;
    logic           w_adv;

    // skid register for one parked result
    logic           r_skid_vld;
    logic [W-1:0]   r_skid [2][4];

    logic signed [W-1:0]   w_n [3];
    logic signed [W-1:0]   w_c [3];
    logic signed [W:0]     w_m [3][3];
    logic signed [W:0]     w_mf [3][3];

    logic [W+2:0]          w_arg  [2];
    logic signed [W+1:0]   w_num  [2][3];
    t_main                 w_idx  [2];
    logic [SIDE_W-1:0]     w_side [2];
    logic [SW-1:0]         w_s    [2];
    logic [SIDE_W-1:0]     w_sdo  [2];
    logic signed [W+1:0]   w_dnum [2][3];
    t_main                 w_didx [2];
    logic signed [W-1:0]   w_q    [2][4];

    // the whole pipeline moves while the skid is empty
    assign w_adv      = !r_skid_vld;
    assign o_in_ready = w_adv;

    assign w_n[0] = i_normal_x;
    assign w_n[1] = i_normal_y;
    assign w_n[2] = i_normal_z;
    assign w_c[0] = i_curv_dir_x;
    assign w_c[1] = i_curv_dir_y;
    assign w_c[2] = i_curv_dir_z;

    sfq_frame #(.W(W), .F(FRAC_BITS)) u_frame (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_n   (w_n),
        .i_c   (w_c),
        .o_m   (w_m)
    );

    // flipped frame: second and third columns negated, kept one bit wider
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mf[i][0] = w_m[i][0];
            w_mf[i][1] = -w_m[i][1];
            w_mf[i][2] = -w_m[i][2];
        end
    end

    sfq_branch #(.W(W), .F(FRAC_BITS)) u_branch_quat (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_m   (w_m),
        .o_arg (w_arg[0]),
        .o_num (w_num[0]),
        .o_idx (w_idx[0])
    );

    sfq_branch #(.W(W), .F(FRAC_BITS)) u_branch_flip (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_m   (w_mf),
        .o_arg (w_arg[1]),
        .o_num (w_num[1]),
        .o_idx (w_idx[1])
    );

    for (genvar h = 0; h < 2; h++) begin : g_half
        // numerators and branch ride through the root stages
        assign w_side[h] = {w_num[h][0], w_num[h][1], w_num[h][2], w_idx[h]};

        sfq_sqrt #(.W(W), .F(FRAC_BITS), .SIDE_W(SIDE_W)) u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_arg  (w_arg[h]),
            .i_side (w_side[h]),
            .o_s    (w_s[h]),
            .o_side (w_sdo[h])
        );

        assign w_dnum[h][0] = w_sdo[h][SIDE_W-1 -: W+2];
        assign w_dnum[h][1] = w_sdo[h][2*(W+2)+1 -: W+2];
        assign w_dnum[h][2] = w_sdo[h][W+3 -: W+2];
        assign w_didx[h]    = t_main'(w_sdo[h][1:0]);

        sfq_div #(.W(W), .F(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_s   (w_s[h]),
            .i_num (w_dnum[h]),
            .i_idx (w_didx[h]),
            .o_q   (w_q[h])
        );
    end

    // valid bits shift with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // park the last stage's item when the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_out_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[NST-1] && !i_out_ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            for (int h = 0; h < 2; h++) begin
                for (int t = 0; t < 4; t++) begin
                    r_skid[h][t] <= w_q[h][t];
                end
            end
        end
    end

    // skid item goes out first, else the last stage directly
    assign o_out_valid = r_skid_vld || r_vld[NST-1];

    assign o_quat_w = r_skid_vld ? r_skid[0][0] : w_q[0][0];
    assign o_quat_x = r_skid_vld ? r_skid[0][1] : w_q[0][1];
    assign o_quat_y = r_skid_vld ? r_skid[0][2] : w_q[0][2];
    assign o_quat_z = r_skid_vld ? r_skid[0][3] : w_q[0][3];
    assign o_flip_w = r_skid_vld ? r_skid[1][0] : w_q[1][0];
    assign o_flip_x = r_skid_vld ? r_skid[1][1] : w_q[1][1];
    assign o_flip_y = r_skid_vld ? r_skid[1][2] : w_q[1][2];
    assign o_flip_z = r_skid_vld ? r_skid[1][3] : w_q[1][3];

endmodule

[hw/rtl/sfq_frame.sv]
// cross product stage: builds the rotation matrix from normal and direction
module sfq_frame
    import sfq_pkg::*;
#(
    parameter int W = SAMPLE_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_n [3],
    input  logic signed [W-1:0] i_c [3],
    output logic signed [W:0]   o_m [3][3]
);

    localparam logic signed [2*W:0]   HALF = (2*W+1)'(1) << (F - 1);
    localparam logic signed [2*W+1:0] SMAX = {{(W+3){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W+1:0] SMIN = {{(W+3){1'b1}}, {(W-1){1'b0}}};

    logic signed [W-1:0]   r_n [3];
    logic signed [W-1:0]   r_c [3];
    logic signed [2*W-1:0] r_p [6];
    logic signed [W:0]     r_m [3][3];
    logic signed [W:0]     n_x [3];

    // products, in pairs whose difference is one cross component
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= i_n;
            r_c    <= i_c;
            r_p[0] <= i_n[1] * i_c[2];
            r_p[1] <= i_n[2] * i_c[1];
            r_p[2] <= i_n[2] * i_c[0];
            r_p[3] <= i_n[0] * i_c[2];
            r_p[4] <= i_n[0] * i_c[1];
            r_p[5] <= i_n[1] * i_c[0];
        end
    end

    // round half up to f fraction bits, subtract, saturate
    always_comb begin
        logic signed [2*W:0]   a;
        logic signed [2*W:0]   b;
        logic signed [2*W+1:0] d;
        for (int k = 0; k < 3; k++) begin
            a = ($signed({r_p[2*k][2*W-1], r_p[2*k]}) + HALF) >>> F;
            b = ($signed({r_p[2*k+1][2*W-1], r_p[2*k+1]}) + HALF) >>> F;
            d = {a[2*W], a} - {b[2*W], b};
            if (d > SMAX) begin
                n_x[k] = {2'b00, {(W-1){1'b1}}};
            end else if (d < SMIN) begin
                n_x[k] = {2'b11, {(W-1){1'b0}}};
            end else begin
                n_x[k] = d[W:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i][0] <= {r_n[i][W-1], r_n[i]};
                r_m[i][1] <= {r_c[i][W-1], r_c[i]};
                r_m[i][2] <= n_x[i];
            end
        end
    end

    assign o_m = r_m;

endmodule

[hw/rtl/sfq_branch.sv]
// trace branch select: square-root argument, numerators and main component
module sfq_branch
    import sfq_pkg::*;
#(
    parameter int W = SAMPLE_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W:0]   i_m [3][3],
    output logic [W+2:0]        o_arg,
    output logic signed [W+1:0] o_num [3],
    output t_main               o_idx
);

    localparam int AW   = W + 3;
    localparam int CAPB = 62 - F;
    localparam logic [AW:0] CAPV = (CAPB >= AW) ? {1'b0, {AW{1'b1}}}
                                                : (((AW+1)'(1) << CAPB) - (AW+1)'(1));
    localparam logic signed [W+3:0] ONE = (W+4)'(1) << F;

    logic [AW-1:0]       r_arg;
    logic signed [W+1:0] r_num [3];
    t_main               r_idx;

    logic [AW-1:0]       n_arg;
    logic signed [W+1:0] n_num [3];
    t_main               n_idx;

    always_comb begin
        logic signed [W+3:0] a00, a11, a22, tr, arg;
        logic signed [W+1:0] m01, m02, m10, m12, m20, m21;
        a00 = (W+4)'(i_m[0][0]);
        a11 = (W+4)'(i_m[1][1]);
        a22 = (W+4)'(i_m[2][2]);
        m01 = (W+2)'(i_m[0][1]);
        m02 = (W+2)'(i_m[0][2]);
        m10 = (W+2)'(i_m[1][0]);
        m12 = (W+2)'(i_m[1][2]);
        m20 = (W+2)'(i_m[2][0]);
        m21 = (W+2)'(i_m[2][1]);
        tr  = a00 + a11 + a22;
        if (tr > 0) begin
            n_idx    = MAIN_W;
            arg      = tr + ONE;
            n_num[0] = m21 - m12;
            n_num[1] = m02 - m20;
            n_num[2] = m10 - m01;
        end else if (a00 > a11 && a00 > a22) begin
            n_idx    = MAIN_X;
            arg      = ONE + a00 - a11 - a22;
            n_num[0] = m21 - m12;
            n_num[1] = m01 + m10;
            n_num[2] = m02 + m20;
        end else if (a11 > a22) begin
            n_idx    = MAIN_Y;
            arg      = ONE + a11 - a00 - a22;
            n_num[0] = m02 - m20;
            n_num[1] = m01 + m10;
            n_num[2] = m12 + m21;
        end else begin
            n_idx    = MAIN_Z;
            arg      = ONE + a22 - a00 - a11;
            n_num[0] = m10 - m01;
            n_num[1] = m02 + m20;
            n_num[2] = m12 + m21;
        end
        // clamp at zero and at the cap
        if (arg[W+3]) begin
            n_arg = '0;
        end else if ({1'b0, arg[AW-1:0]} > CAPV) begin
            n_arg = CAPV[AW-1:0];
        end else begin
            n_arg = arg[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arg <= n_arg;
            r_num <= n_num;
            r_idx <= n_idx;
        end
    end

    assign o_arg = r_arg;
    assign o_num = r_num;
    assign o_idx = r_idx;

endmodule

[hw/rtl/sfq_sqrt.sv]
// pipelined integer square root, one result bit per stage, side data rides along
module sfq_sqrt
    import sfq_pkg::*;
#(
    parameter int W      = SAMPLE_WIDTH_DEF,
    parameter int F      = FRAC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [W+2:0]                         i_arg,
    input  logic [SIDE_W-1:0]                    i_side,
    output logic [sqrt_bits(W, F)-1:0]           o_s,
    output logic [SIDE_W-1:0]                    o_side
);

    localparam int SW  = sqrt_bits(W, F);
    localparam int RW  = W + 3 + F + 2;
    localparam int RW2 = 2 * SW;

    logic [SW+2:0]     r_rem  [SW];
    logic [SW-1:0]     r_root [SW];
    logic [RW2-1:0]    r_rad  [SW];
    logic [SIDE_W-1:0] r_side [SW];

    logic [RW-1:0]     w_rad0;
    assign w_rad0 = {i_arg, {(F+2){1'b0}}};

    for (genvar g = 0; g < SW; g++) begin : g_stage
        logic [SW+2:0]     rem_in;
        logic [SW-1:0]     root_in;
        logic [RW2-1:0]    rad_in;
        logic [SIDE_W-1:0] side_in;
        logic [SW+2:0]     rem_cat;
        logic [SW+2:0]     trial;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RW2'(w_rad0);
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign rad_in  = r_rad[g-1];
            assign side_in = r_side[g-1];
        end

        assign rem_cat = {rem_in[SW:0], rad_in[RW2-1 -: 2]};
        assign trial   = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_cat >= trial) begin
                    r_rem[g]  <= rem_cat - trial;
                    r_root[g] <= {root_in[SW-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= rem_cat;
                    r_root[g] <= {root_in[SW-2:0], 1'b0};
                end
                r_rad[g]  <= rad_in << 2;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_s    = r_root[SW-1];
    assign o_side = r_side[SW-1];

endmodule

[hw/rtl/sfq_div.sv]
// pipelined restoring divide of three numerators by the root, then assembly
module sfq_div
    import sfq_pkg::*;
#(
    parameter int W = SAMPLE_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sqrt_bits(W, F)-1:0]  i_s,
    input  logic signed [W+1:0]         i_num [3],
    input  t_main                       i_idx,
    output logic signed [W-1:0]         o_q [4]
);

    localparam int SW  = sqrt_bits(W, F);
    localparam int QB  = W + 1;
    localparam int DW  = W + F + 4;
    localparam int RMW = SW + 1 + QB;
    localparam int XW  = (DW > RMW) ? DW : RMW;
    localparam logic [QB-1:0] POS_LIM = {2'b00, {(W-1){1'b1}}};
    localparam logic [QB-1:0] NEG_LIM = {2'b01, {(W-1){1'b0}}};

    logic [RMW-1:0] r_rem  [QB+1][3];
    logic [QB-1:0]  r_q    [QB+1][3];
    logic           r_neg  [QB+1][3];
    logic           r_ovf  [QB+1][3];
    logic [SW:0]    r_dvs  [QB+1];
    logic           r_zero [QB+1];
    logic [W-1:0]   r_main [QB+1];
    t_main          r_idx  [QB+1];

    logic signed [W-1:0] r_out [4];

    // prep: magnitude, rounded dividend, overflow and main component
    always_ff @(posedge i_clk) begin
        logic [W+1:0]   mag;
        logic [XW-1:0]  dd;
        logic [XW-1:0]  lim;
        logic [XW-1:0]  mv;
        if (i_en) begin
            lim = XW'({i_s, 1'b0}) << QB;
            for (int k = 0; k < 3; k++) begin
                mag = i_num[k][W+1] ? (W+2)'(-i_num[k]) : i_num[k];
                dd  = (XW'(mag) << (F + 1)) + XW'(i_s);
                r_neg[0][k] <= i_num[k][W+1];
                r_ovf[0][k] <= (dd >= lim);
                r_rem[0][k] <= dd[RMW-1:0];
                r_q[0][k]   <= '0;
            end
            mv = (XW'(i_s) + XW'(2)) >> 2;
            if (mv > XW'(POS_LIM)) begin
                r_main[0] <= POS_LIM[W-1:0];
            end else begin
                r_main[0] <= mv[W-1:0];
            end
            r_dvs[0]  <= {i_s, 1'b0};
            r_zero[0] <= (i_s == '0);
            r_idx[0]  <= i_idx;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j <= QB; j++) begin : g_bit
        logic [RMW-1:0] trial;
        assign trial = RMW'(r_dvs[j-1]) << (QB - j);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[j-1][k] >= trial) begin
                        r_rem[j][k] <= r_rem[j-1][k] - trial;
                        r_q[j][k]   <= r_q[j-1][k] | (QB'(1) << (QB - j));
                    end else begin
                        r_rem[j][k] <= r_rem[j-1][k];
                        r_q[j][k]   <= r_q[j-1][k];
                    end
                    r_neg[j][k] <= r_neg[j-1][k];
                    r_ovf[j][k] <= r_ovf[j-1][k];
                end
                r_dvs[j]  <= r_dvs[j-1];
                r_zero[j] <= r_zero[j-1];
                r_main[j] <= r_main[j-1];
                r_idx[j]  <= r_idx[j-1];
            end
        end
    end

    // saturate and place the components around the main one
    always_ff @(posedge i_clk) begin
        logic [W-1:0] comp [3];
        logic [QB-1:0] qv;
        logic [1:0]   sel;
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                qv = r_q[QB][k];
                if (r_zero[QB]) begin
                    comp[k] = '0;
                end else if (r_neg[QB][k]) begin
                    if (r_ovf[QB][k] || qv > NEG_LIM) begin
                        comp[k] = NEG_LIM[W-1:0];
                    end else begin
                        comp[k] = W'(-qv);
                    end
                end else begin
                    if (r_ovf[QB][k] || qv > POS_LIM) begin
                        comp[k] = POS_LIM[W-1:0];
                    end else begin
                        comp[k] = qv[W-1:0];
                    end
                end
            end
            for (int t = 0; t < 4; t++) begin
                sel = (2'(t) > r_idx[QB]) ? 2'(t - 1) : 2'(t);
                if (2'(t) == r_idx[QB]) begin
                    r_out[t] <= r_main[QB];
                end else begin
                    r_out[t] <= comp[sel];
                end
            end
        end
    end

    assign o_q = r_out;

endmodule

[tb/tb_surface_frame_to_quaternion_pair.sv]
// testbench for the surface frame to quaternion pair block
`timescale 1ns / 100ps

module tb_surface_frame_to_quaternion_pair
    import sfq_pkg::*;
;

    localparam int SW   = SAMPLE_WIDTH_DEF;
    localparam int FB   = FRAC_BITS_DEF;
    localparam int LAT  = 40;
    localparam int N_RANDOM = 1250;

    typedef logic signed [SW-1:0] t_smp;

    // one point in, one quaternion pair out
    typedef struct packed {
        t_smp nx, ny, nz, cx, cy, cz;
    } t_point;

    typedef struct packed {
        t_smp qw, qx, qy, qz, fw, fx, fy, fz;
    } t_quat_pair;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready;
    t_smp i_normal_x, i_normal_y, i_normal_z;
    t_smp i_curv_dir_x, i_curv_dir_y, i_curv_dir_z;
    logic o_out_valid, i_out_ready;
    t_smp o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    t_smp o_flip_w, o_flip_x, o_flip_y, o_flip_z;

    surface_frame_to_quaternion_pair u_top (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------- quaternion predictor ----------------
    localparam longint VMAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint VMIN = -(64'sd1 <<< (SW - 1));
    localparam longint ONE  = 64'sd1 <<< FB;
    localparam longint ARGMAX = (64'sd1 <<< (62 - FB)) - 1;

    function automatic longint clip(input longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // product rounded half up to FB fraction bits (floor of shifted sum)
    function automatic longint rnd_prod(input longint p);
        return (p + (ONE >>> 1)) >>> FB;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // numerator / root, nearest with ties away from zero, saturated
    function automatic longint div_root(input longint num, input longint unsigned s);
        longint unsigned mag, q;
        if (s == 0) return 0;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = ((mag << (FB + 1)) + s) / (s << 1);
        if (num < 0) begin
            if (q > longint'(VMAX) + 1) q = longint'(VMAX) + 1;
            return -longint'(q);
        end
        if (q > longint'(VMAX)) q = VMAX;
        return longint'(q);
    endfunction

    // rotation matrix to quaternion, four branches with strict compares
    function automatic void mat_to_quat(input longint m[3][3], output longint q[4]);
        longint tr, arg;
        longint num[4];
        longint unsigned s;
        t_main mi;
        tr = m[0][0] + m[1][1] + m[2][2];
        num = '{0, 0, 0, 0};
        if (tr > 0) begin
            mi = MAIN_W;
            arg = tr + ONE;
            num[1] = m[2][1] - m[1][2];
            num[2] = m[0][2] - m[2][0];
            num[3] = m[1][0] - m[0][1];
        end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
            mi = MAIN_X;
            arg = ONE + m[0][0] - m[1][1] - m[2][2];
            num[0] = m[2][1] - m[1][2];
            num[2] = m[0][1] + m[1][0];
            num[3] = m[0][2] + m[2][0];
        end else if (m[1][1] > m[2][2]) begin
            mi = MAIN_Y;
            arg = ONE + m[1][1] - m[0][0] - m[2][2];
            num[0] = m[0][2] - m[2][0];
            num[1] = m[0][1] + m[1][0];
            num[3] = m[1][2] + m[2][1];
        end else begin
            mi = MAIN_Z;
            arg = ONE + m[2][2] - m[0][0] - m[1][1];
            num[0] = m[1][0] - m[0][1];
            num[1] = m[0][2] + m[2][0];
            num[2] = m[1][2] + m[2][1];
        end
        // negative argument clamps to zero, huge one to the cap
        if (arg < 0) arg = 0;
        if (arg > ARGMAX) arg = ARGMAX;
        s = int_sqrt(longint'(arg) << (FB + 2));
        for (int k = 0; k < 4; k++) begin
            if (k == int'(mi)) q[k] = clip(longint'((s + 2) >> 2));
            else q[k] = div_root(num[k], s);
        end
    endfunction

    function automatic t_quat_pair predict_pair(input t_point p);
        longint n[3], c[3], m[3][3], q[4];
        t_quat_pair r;
        n = '{p.nx, p.ny, p.nz};
        c = '{p.cx, p.cy, p.cz};
        for (int i = 0; i < 3; i++) begin
            m[i][0] = n[i];
            m[i][1] = c[i];
        end
        m[0][2] = clip(rnd_prod(n[1] * c[2]) - rnd_prod(n[2] * c[1]));
        m[1][2] = clip(rnd_prod(n[2] * c[0]) - rnd_prod(n[0] * c[2]));
        m[2][2] = clip(rnd_prod(n[0] * c[1]) - rnd_prod(n[1] * c[0]));
        mat_to_quat(m, q);
        r.qw = t_smp'(q[0]); r.qx = t_smp'(q[1]); r.qy = t_smp'(q[2]); r.qz = t_smp'(q[3]);
        // flipped frame: columns two and three negated, kept at full width
        for (int i = 0; i < 3; i++) begin
            m[i][1] = -m[i][1];
            m[i][2] = -m[i][2];
        end
        mat_to_quat(m, q);
        r.fw = t_smp'(q[0]); r.fx = t_smp'(q[1]); r.fy = t_smp'(q[2]); r.fz = t_smp'(q[3]);
        return r;
    endfunction

    // ---------------- stimulus ----------------
    t_point     pending_points[$];
    t_quat_pair expected_pairs[$];
    int         n_errors = 0;
    int         n_checked = 0;
    bit         stim_done = 0;
    bit         hold_sender = 0;

    function automatic t_smp unit_q(input real v);
        return t_smp'($rtoi(v * real'(ONE) + (v >= 0 ? 0.5 : -0.5)));
    endfunction

    function automatic t_smp rand_smp();
        return t_smp'($urandom_range(0, (1 << SW) - 1));
    endfunction

    // random unit normal and an orthogonal unit direction, small jitter
    function automatic t_point rand_frame();
        real ax, ay, az, bx, by, bz, l, d;
        t_point p;
        ax = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        ay = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        az = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        l = $sqrt(ax * ax + ay * ay + az * az);
        if (l < 1e-3) begin ax = 1.0; l = 1.0; ay = 0; az = 0; end
        ax = ax / l; ay = ay / l; az = az / l;
        bx = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        by = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        bz = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        d = ax * bx + ay * by + az * bz;
        bx = bx - d * ax; by = by - d * ay; bz = bz - d * az;
        l = $sqrt(bx * bx + by * by + bz * bz);
        if (l < 1e-3) begin
            bx = -ay; by = ax; bz = 0;
            l = $sqrt(bx * bx + by * by);
            if (l < 1e-3) begin bx = 0; by = 1; l = 1; end
        end
        bx = bx / l; by = by / l; bz = bz / l;
        p.nx = unit_q(ax) + t_smp'($urandom_range(0, 2)) - 1;
        p.ny = unit_q(ay);
        p.nz = unit_q(az);
        p.cx = unit_q(bx);
        p.cy = unit_q(by) + t_smp'($urandom_range(0, 2)) - 1;
        p.cz = unit_q(bz);
        return p;
    endfunction

    function automatic t_point mk(input t_smp a, b, c, d, e, f);
        t_point p;
        p.nx = a; p.ny = b; p.nz = c; p.cx = d; p.cy = e; p.cz = f;
        return p;
    endfunction

    localparam t_smp P1 = t_smp'(ONE);
    localparam t_smp M1 = -t_smp'(ONE);
    localparam t_smp SMAX = t_smp'(VMAX);
    localparam t_smp SMIN = t_smp'(VMIN);

    initial begin
        t_point p;
        i_rst_n = 1'b0;
        // directed: identity and each main-component branch
        pending_points.push_back(mk(P1, 0, 0, 0, P1, 0));     // trace positive
        pending_points.push_back(mk(P1, 0, 0, 0, M1, 0));     // x branch
        pending_points.push_back(mk(M1, 0, 0, 0, P1, 0));     // y branch
        pending_points.push_back(mk(M1, 0, 0, 0, M1, 0));     // z branch
        pending_points.push_back(mk(0, P1, 0, P1, 0, 0));
        pending_points.push_back(mk(0, 0, P1, P1, 0, 0));
        // all zero: zero trace and tied diagonal fall to the z branch
        pending_points.push_back(mk(0, 0, 0, 0, 0, 0));
        // field extremes, saturation and most negative entries negated
        pending_points.push_back(mk(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX));
        pending_points.push_back(mk(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN));
        pending_points.push_back(mk(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN));
        pending_points.push_back(mk(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX));
        pending_points.push_back(mk(SMIN, 0, 0, 0, SMIN, 0));
        pending_points.push_back(mk(SMAX, 0, 0, 0, SMAX, SMIN));
        pending_points.push_back(mk(-1, -1, -1, -1, -1, -1));
        pending_points.push_back(mk(1, 1, 1, 1, 1, 1));
        // ties between diagonal entries
        pending_points.push_back(mk(0, 0, M1, 0, 0, P1));
        pending_points.push_back(mk(unit_q(0.5), 0, 0, 0, unit_q(0.5), 0));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // random: mostly near-unit frames, some raw noise
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 9) < 8) p = rand_frame();
            else p = mk(rand_smp(), rand_smp(), rand_smp(),
                        rand_smp(), rand_smp(), rand_smp());
            pending_points.push_back(p);
            if (i == N_RANDOM / 2) begin
                // pause the sender until everything in flight has drained
                wait (pending_points.size() == 0);
                hold_sender = 1;
                wait (expected_pairs.size() == 0);
                hold_sender = 0;
            end
        end
        stim_done = 1;
    end

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left = 0;

    initial begin
        i_in_valid = 1'b0;
        {i_normal_x, i_normal_y, i_normal_z} = '0;
        {i_curv_dir_x, i_curv_dir_y, i_curv_dir_z} = '0;
        i_out_ready = 1'b0;
    end

    // the head of the queue is the item on the bus, popped when it is accepted
    task automatic p_drive();
        t_point p;
        p = pending_points[0];
        i_in_valid   <= 1'b1;
        i_normal_x   <= p.nx;
        i_normal_y   <= p.ny;
        i_normal_z   <= p.nz;
        i_curv_dir_x <= p.cx;
        i_curv_dir_y <= p.cy;
        i_curv_dir_z <= p.cz;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // item accepted this edge: record what it should produce
            if (i_in_valid && o_in_ready) begin
                expected_pairs.push_back(predict_pair(pending_points.pop_front()));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (!hold_sender && pending_points.size() > 0) begin
                    p_drive();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int stall_phase = 0;

    task automatic report_field(input string name, input t_smp want, input t_smp got);
        if (n_errors < 50)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin
        t_quat_pair got, want;
        if (i_rst_n) begin
            // receiver: long open stretches, then bursty stalls
            stall_phase <= (stall_phase + 1) % 300;
            if (stall_phase < 100) i_out_ready <= 1'b1;
            else if (stall_phase < 200) i_out_ready <= ($urandom_range(0, 2) != 0);
            else i_out_ready <= ($urandom_range(0, 3) == 0);
            if (o_out_valid && i_out_ready) begin
                got = '{o_quat_w, o_quat_x, o_quat_y, o_quat_z,
                        o_flip_w, o_flip_x, o_flip_y, o_flip_z};
                if (expected_pairs.size() == 0) begin
                    $display("%0t: unexpected item, actual %h", $time, got);
                    n_errors++;
                end else begin
                    want = expected_pairs.pop_front();
                    n_checked++;
                    if (got != want) begin
                        n_errors++;
                        if (got.qw != want.qw) report_field("quat_w", want.qw, got.qw);
                        if (got.qx != want.qx) report_field("quat_x", want.qx, got.qx);
                        if (got.qy != want.qy) report_field("quat_y", want.qy, got.qy);
                        if (got.qz != want.qz) report_field("quat_z", want.qz, got.qz);
                        if (got.fw != want.fw) report_field("flip_w", want.fw, got.fw);
                        if (got.fx != want.fx) report_field("flip_x", want.fx, got.fx);
                        if (got.fy != want.fy) report_field("flip_y", want.fy, got.fy);
                        if (got.fz != want.fz) report_field("flip_z", want.fz, got.fz);
                    end
                end
            end
        end
    end

    // ---------------- end of run ----------------
    initial begin
        wait (stim_done && pending_points.size() == 0 && !i_in_valid
              && expected_pairs.size() == 0);
        repeat (LAT * 3) @(posedge i_clk);
        $display("checked %0d quaternion pairs: branch corners, field extremes,", n_checked);
        $display("near-unit random frames and raw noise under bursty flow control");
        if (n_errors == 0 && expected_pairs.size() == 0) begin
            $display("PASS surface_frame_to_quaternion_pair");
        end else begin
            $display("FAIL surface_frame_to_quaternion_pair");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL surface_frame_to_quaternion_pair");
        $finish;
    end

endmodule

[files.f]
hw/rtl/sfq_pkg.sv
hw/rtl/sfq_frame.sv
hw/rtl/sfq_branch.sv
hw/rtl/sfq_sqrt.sv
hw/rtl/sfq_div.sv
hw/rtl/surface_frame_to_quaternion_pair.sv
tb/tb_surface_frame_to_quaternion_pair.sv
